>>> rtl/core/polygon_mask_pixel_patch_core_assert.svh
// Assertion macros for the polygon mask pixel patch core.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef POLYGON_MASK_PIXEL_PATCH_CORE_ASSERT_SVH
`define POLYGON_MASK_PIXEL_PATCH_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent
`define PMPP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmpp: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define PMPP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmpp: next-cycle check failed");

`else

`define PMPP_ASSERT_IMP(lbl, ante, cons)

`define PMPP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> rtl/core/pmpp_pkg.sv
package pmpp_pkg;

    localparam int COORD_BITS   = 13;
    localparam int MAX_VERTICES = 64;
    localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
    localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
    localparam int RGB_BITS     = 24;
    localparam int FUNC_BITS    = 2;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;

    localparam logic [CNT_BITS-1:0]   MAX_CNT       = CNT_BITS'(MAX_VERTICES);
    localparam logic [CNT_BITS-1:0]   MIN_POLY_CNT  = CNT_BITS'(3);
    localparam logic [COORD_BITS-1:0] RAY_END_RESET = COORD_BITS'(5000);

    // Operation codes
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_TEST   = 2'd2;

    typedef logic [COORD_BITS-1:0]       coord_t;
    typedef logic signed [DIFF_BITS-1:0] diff_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic [RGB_BITS-1:0]         rgb_t;

    typedef enum logic [1:0] {
        ORI_COL = 2'd0,
        ORI_CW  = 2'd1,
        ORI_CCW = 2'd2
    } orient_t;

    // Controller to datapath
    typedef struct packed {
        logic                 take;
        logic                 clr_cnt;
        logic                 wr_vtx;
        logic                 note_drop;
        logic                 acc_clr;
        logic                 rd_en;
        logic                 rd_first;
        logic [ADDR_BITS-1:0] rd_addr;
        logic                 emit;
    } pmpp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic [CNT_BITS-1:0]  vcnt;
        logic                 full;
        logic                 pipe_busy;
        logic                 out_free;
    } pmpp_stat_t;

    // Signed difference a - b of two unsigned coordinates
    function automatic diff_t coord_diff(coord_t a, coord_t b);
        diff_t d;
        d = diff_t'({1'b0, a}) - diff_t'({1'b0, b});
        return d;
    endfunction

    // Orientation code from the sign of a cross product
    function automatic orient_t orient_of(prod_t v);
        orient_t o;
        if (v == '0)
            o = ORI_COL;
        else if (!v[PROD_BITS-1])
            o = ORI_CW;
        else
            o = ORI_CCW;
        return o;
    endfunction

    // Orientation against the horizontal ray: value is -(dfp * dv)
    function automatic orient_t orient_horiz(diff_t dfp, diff_t dv);
        orient_t o;
        if (dfp == '0 || dv == '0)
            o = ORI_COL;
        else if (dfp[DIFF_BITS-1] != dv[DIFF_BITS-1])
            o = ORI_CW;
        else
            o = ORI_CCW;
        return o;
    endfunction

    // Point b lies in the bounding box of a and c
    function automatic logic in_box(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                    coord_t cx, coord_t cy);
        coord_t xlo;
        coord_t xhi;
        coord_t ylo;
        coord_t yhi;
        xlo = (ax < cx) ? ax : cx;
        xhi = (ax < cx) ? cx : ax;
        ylo = (ay < cy) ? ay : cy;
        yhi = (ay < cy) ? cy : ay;
        return (bx >= xlo) && (bx <= xhi) && (by >= ylo) && (by <= yhi);
    endfunction

endpackage

>>> rtl/core/pmpp_ctrl.sv
module pmpp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pmpp_pkg::pmpp_stat_t  stat,
    output pmpp_pkg::pmpp_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [pmpp_pkg::CNT_BITS-1:0]   walk_reg;
    logic [pmpp_pkg::CNT_BITS-1:0]   walk_next;
    logic                            walk_last;

    // Read index runs 0 .. vcnt-1, then wraps back to vertex 0 to close
    assign walk_last = (walk_reg == stat.vcnt);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        walk_next  = walk_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_EMIT;
                unique case (stat.func)
                    pmpp_pkg::FUNC_CLEAR:
                        cmd.clr_cnt = 1'b1;
                    pmpp_pkg::FUNC_APPEND:
                    begin
                        if (stat.full)
                            cmd.note_drop = 1'b1;
                        else
                            cmd.wr_vtx = 1'b1;
                    end
                    pmpp_pkg::FUNC_TEST:
                    begin
                        cmd.acc_clr = 1'b1;
                        if (stat.vcnt >= pmpp_pkg::MIN_POLY_CNT)
                        begin
                            walk_next  = '0;
                            state_next = ST_WALK;
                        end
                    end
                    default:
                        cmd.clr_cnt = 1'b0;
                endcase
            end
            ST_WALK:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (walk_reg == '0);
                cmd.rd_addr  = walk_last ? '0 : walk_reg[pmpp_pkg::ADDR_BITS-1:0];
                walk_next    = walk_reg + 1'b1;
                if (walk_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Hold state and walk index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            walk_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
        end
    end

endmodule

>>> rtl/core/pmpp_dp.sv
module pmpp_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [pmpp_pkg::COORD_BITS-1:0]     cfg_wr_data,
    input  logic [pmpp_pkg::FUNC_BITS-1:0]      func,
    input  logic [pmpp_pkg::COORD_BITS-1:0]     coord_x,
    input  logic [pmpp_pkg::COORD_BITS-1:0]     coord_y,
    input  logic [pmpp_pkg::RGB_BITS-1:0]       base_pixel,
    input  logic [pmpp_pkg::RGB_BITS-1:0]       patch_pixel,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pmpp_pkg::RGB_BITS-1:0]       pixel_out,
    output logic                                inside_res,
    output logic                                status,
    input  pmpp_pkg::pmpp_cmd_t                 cmd,
    output pmpp_pkg::pmpp_stat_t                stat
);

    localparam int VTX_BITS = 2 * pmpp_pkg::COORD_BITS;

    // Configuration and item registers
    pmpp_pkg::coord_t                 ray_end_reg;
    logic [pmpp_pkg::FUNC_BITS-1:0]   func_reg;
    pmpp_pkg::coord_t                 px_reg;
    pmpp_pkg::coord_t                 py_reg;
    pmpp_pkg::rgb_t                   base_reg;
    pmpp_pkg::rgb_t                   patch_reg;
    logic                             drop_reg;
    logic [pmpp_pkg::CNT_BITS-1:0]    cnt_reg;

    // Vertex memory and read stage
    logic [VTX_BITS-1:0]              vtx_mem [pmpp_pkg::MAX_VERTICES];
    logic                             rd_vld_reg;
    logic                             rd_first_reg;
    pmpp_pkg::coord_t                 rd_x_reg;
    pmpp_pkg::coord_t                 rd_y_reg;
    pmpp_pkg::coord_t                 prev_x_reg;
    pmpp_pkg::coord_t                 prev_y_reg;

    // Edge stage A (products) results
    pmpp_pkg::diff_t                  dy_ba;
    pmpp_pkg::diff_t                  dx_ba;
    pmpp_pkg::diff_t                  dx_pb;
    pmpp_pkg::diff_t                  dx_fb;
    pmpp_pkg::diff_t                  dy_pb;
    pmpp_pkg::diff_t                  dx_fp;
    pmpp_pkg::diff_t                  dy_ap;
    logic                             ea_vld;

    logic                             eb_vld_reg;
    pmpp_pkg::prod_t                  m0_reg;
    pmpp_pkg::prod_t                  m1_reg;
    pmpp_pkg::prod_t                  m2_reg;
    pmpp_pkg::orient_t                o3_reg;
    pmpp_pkg::orient_t                o4_reg;
    logic                             w1_reg;
    logic                             w2_reg;
    logic                             w3_reg;
    logic                             w4_reg;

    // Edge stage B (decision)
    pmpp_pkg::prod_t                  v1;
    pmpp_pkg::prod_t                  v2;
    pmpp_pkg::orient_t                o1;
    pmpp_pkg::orient_t                o2;
    logic                             meet;

    logic                             dec_reg;
    logic                             ins_dec_reg;
    logic                             cross_reg;

    // Output register
    logic                             out_vld_reg;
    pmpp_pkg::rgb_t                   pixel_reg;
    logic                             inside_reg;
    logic                             status_reg;
    logic                             out_free;
    logic                             poly_ok;
    logic                             is_test;
    logic                             ins;

    // Ray end register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ray_end_reg <= pmpp_pkg::RAY_END_RESET;
        else if (cfg_wr_en)
            ray_end_reg <= cfg_wr_data;
    end

    // Capture the item on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            func_reg  <= func;
            px_reg    <= coord_x;
            py_reg    <= coord_y;
            base_reg  <= base_pixel;
            patch_reg <= patch_pixel;
        end
    end

    // Track a dropped append
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drop_reg <= 1'b0;
        else if (cmd.take)
            drop_reg <= 1'b0;
        else if (cmd.note_drop)
            drop_reg <= 1'b1;
    end

    // Vertex count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.clr_cnt)
            cnt_reg <= '0;
        else if (cmd.wr_vtx)
            cnt_reg <= cnt_reg + 1'b1;
    end

    // Vertex memory write port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_vtx)
            vtx_mem[cnt_reg[pmpp_pkg::ADDR_BITS-1:0]] <= {px_reg, py_reg};
    end

    // Vertex memory read port
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            {rd_x_reg, rd_y_reg} <= vtx_mem[cmd.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= cmd.rd_en;
            rd_first_reg <= cmd.rd_first;
        end
    end

    // Keep the previous vertex as the start of the next edge
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
        end
    end

    // Stage A: differences for edge a=prev, b=read vertex, ray p..f
    assign ea_vld = rd_vld_reg && !rd_first_reg;
    assign dy_ba  = pmpp_pkg::coord_diff(rd_y_reg, prev_y_reg);
    assign dx_ba  = pmpp_pkg::coord_diff(rd_x_reg, prev_x_reg);
    assign dx_pb  = pmpp_pkg::coord_diff(px_reg, rd_x_reg);
    assign dx_fb  = pmpp_pkg::coord_diff(ray_end_reg, rd_x_reg);
    assign dy_pb  = pmpp_pkg::coord_diff(py_reg, rd_y_reg);
    assign dx_fp  = pmpp_pkg::coord_diff(ray_end_reg, px_reg);
    assign dy_ap  = pmpp_pkg::coord_diff(prev_y_reg, py_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eb_vld_reg <= 1'b0;
        else
            eb_vld_reg <= ea_vld;
    end

    // Register products, ray orientations and box tests
    always_ff @(posedge clk)
    begin
        if (ea_vld)
        begin
            m0_reg <= pmpp_pkg::prod_t'(dy_ba) * pmpp_pkg::prod_t'(dx_pb);
            m1_reg <= pmpp_pkg::prod_t'(dx_ba) * pmpp_pkg::prod_t'(dy_pb);
            m2_reg <= pmpp_pkg::prod_t'(dy_ba) * pmpp_pkg::prod_t'(dx_fb);
            o3_reg <= pmpp_pkg::orient_horiz(dx_fp, dy_ap);
            o4_reg <= pmpp_pkg::orient_horiz(dx_fp, pmpp_pkg::diff_t'(-dy_pb));
            w1_reg <= pmpp_pkg::in_box(prev_x_reg, prev_y_reg, px_reg, py_reg,
                                       rd_x_reg, rd_y_reg);
            w2_reg <= pmpp_pkg::in_box(prev_x_reg, prev_y_reg, ray_end_reg, py_reg,
                                       rd_x_reg, rd_y_reg);
            w3_reg <= pmpp_pkg::in_box(px_reg, py_reg, prev_x_reg, prev_y_reg,
                                       ray_end_reg, py_reg);
            w4_reg <= pmpp_pkg::in_box(px_reg, py_reg, rd_x_reg, rd_y_reg,
                                       ray_end_reg, py_reg);
        end
    end

    // Stage B: edge orientations and intersection
    assign v1 = m0_reg - m1_reg;
    assign v2 = m2_reg - m1_reg;
    assign o1 = pmpp_pkg::orient_of(v1);
    assign o2 = pmpp_pkg::orient_of(v2);
    assign meet = ((o1 != o2) && (o3_reg != o4_reg))
               || ((o1 == pmpp_pkg::ORI_COL) && w1_reg)
               || ((o2 == pmpp_pkg::ORI_COL) && w2_reg)
               || ((o3_reg == pmpp_pkg::ORI_COL) && w3_reg)
               || ((o4_reg == pmpp_pkg::ORI_COL) && w4_reg);

    // Count crossings; the first hit with the point collinear to the edge settles the answer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg     <= 1'b0;
            ins_dec_reg <= 1'b0;
            cross_reg   <= 1'b0;
        end
        else if (cmd.acc_clr)
        begin
            dec_reg     <= 1'b0;
            ins_dec_reg <= 1'b0;
            cross_reg   <= 1'b0;
        end
        else if (eb_vld_reg && !dec_reg && meet)
        begin
            if (o1 == pmpp_pkg::ORI_COL)
            begin
                dec_reg     <= 1'b1;
                ins_dec_reg <= w1_reg;
            end
            else
            begin
                cross_reg <= ~cross_reg;
            end
        end
    end

    // Result fields
    assign poly_ok = (cnt_reg >= pmpp_pkg::MIN_POLY_CNT);
    assign is_test = (func_reg == pmpp_pkg::FUNC_TEST);
    assign ins     = is_test && poly_ok && (dec_reg ? ins_dec_reg : cross_reg);
    assign out_free = !out_vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (cmd.emit)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pixel_reg  <= is_test ? (ins ? patch_reg : base_reg) : '0;
            inside_reg <= ins;
            status_reg <= drop_reg;
        end
    end

    assign out_valid  = out_vld_reg;
    assign pixel_out  = pixel_reg;
    assign inside_res = inside_reg;
    assign status     = status_reg;

    // Status back to the controller
    assign stat.func      = func_reg;
    assign stat.vcnt      = cnt_reg;
    assign stat.full      = (cnt_reg == pmpp_pkg::MAX_CNT);
    assign stat.pipe_busy = rd_vld_reg || eb_vld_reg;
    assign stat.out_free  = out_free;

endmodule

>>> rtl/core/polygon_mask_pixel_patch_core.sv
// Clear and append items are taken one at a time: captured, executed, registered.
// Pixel test with n >= 3 vertices: the single read port of the vertex memory
// reads vertices 0 .. n-1, then vertex 0, feeding one polygon edge per cycle.
// Pixel test with fewer than 3 vertices: no vertex walk, inside_res is 0.
// Reset (rst_n low, asynchronous) zeroes the vertex count and sets ray_end_x
// to 5000; the vertex memory is not cleared.
`include "polygon_mask_pixel_patch_core_assert.svh"

module polygon_mask_pixel_patch_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [pmpp_pkg::COORD_BITS-1:0]     cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pmpp_pkg::FUNC_BITS-1:0]      func,
    input  logic [pmpp_pkg::COORD_BITS-1:0]     coord_x,
    input  logic [pmpp_pkg::COORD_BITS-1:0]     coord_y,
    input  logic [pmpp_pkg::RGB_BITS-1:0]       base_pixel,
    input  logic [pmpp_pkg::RGB_BITS-1:0]       patch_pixel,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pmpp_pkg::RGB_BITS-1:0]       pixel_out,
    output logic                                inside_res,
    output logic                                status
);

    pmpp_pkg::pmpp_cmd_t  cmd;
    pmpp_pkg::pmpp_stat_t stat;

    pmpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pmpp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .func        (func),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .base_pixel  (base_pixel),
        .patch_pixel (patch_pixel),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_out   (pixel_out),
        .inside_res  (inside_res),
        .status      (status),
        .cmd         (cmd),
        .stat        (stat)
    );

    // Checks
    `PMPP_ASSERT_IMP(a_cnt_bound, 1'b1, stat.vcnt <= pmpp_pkg::MAX_CNT)
    `PMPP_ASSERT_IMP(a_rd_in_range, cmd.rd_en, pmpp_pkg::CNT_BITS'(cmd.rd_addr) < stat.vcnt)
    `PMPP_ASSERT_IMP(a_emit_free, cmd.emit, stat.out_free)
    `PMPP_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready)

endmodule
